// ===== src/ic3x3_pkg.sv =====
// ----------------------------------------------------------------------------
// ic3x3_pkg: shared types and constants of the 3x3 image convolution block
// Register map, fixed field widths and reset values of the configuration.
// ----------------------------------------------------------------------------
package ic3x3_pkg;

    // configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    // configuration register widths
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int KERN_REG_W   = 24;

    // result tag widths
    localparam int ROW_W        = 12;
    localparam int OUT_COL_W    = 10;

    // frame and kernel geometry
    localparam int MAX_HEIGHT   = 4096;
    localparam int KSIZE        = 3;
    localparam int WIN_TAPS     = KSIZE * KSIZE;
    localparam int DIVISOR      = 9;

    // reset values of the configuration registers
    localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT = 13'd1024;
    localparam logic [KERN_REG_W-1:0]   RST_KERNEL = 24'h010101;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_reg;

endpackage

// ===== src/image_convolution_3x3_top.sv =====
// ----------------------------------------------------------------------------
// image_convolution_3x3_top: streaming 3x3 convolution over raster-order pixels
// Line store, 3x3 window, kernel multiply-accumulate, divide by nine, saturation.
// ----------------------------------------------------------------------------
// usage
//   input channel: one pixel per beat in raster order, i_frame_start on the
//   first pixel of a frame puts it at row 0, column 0
//   output channel: one result per beat, tagged with row and column; o_last
//   marks the final result caused by an input pixel
//   config channel: always ready, write only while the stream is idle
//   border pixels come out unchanged at once; an interior pixel comes out
//   (filtered) when the pixel below and right of it arrives, ahead of that
//   pixel's own border result if it has one
// timing
//   pixel to outputs: input, product, sum, reciprocal, correction, result registers
//   one pixel per cycle sustained while the receiver keeps up; a pixel with two
//   results holds the input while the single result register sends them in turn
//   line store: MAX_WIDTH words of two pixels, one read and one write a cycle
// reset
//   counters at row 0 column 0, window zero, registers at their defaults;
//   the line store is not cleared, every entry is written before it is used
// stall
//   when the receiver holds ready low the whole pipeline freezes once the
//   last stage has an undelivered result; input ready drops in the same cycle
// ----------------------------------------------------------------------------
module image_convolution_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int COEF_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ic3x3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ic3x3_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [PIXEL_BITS-1:0]          i_pixel,
    input  logic                                  i_frame_start,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [PIXEL_BITS-1:0]          o_value,
    output logic [ic3x3_pkg::ROW_W-1:0]           o_out_row,
    output logic [ic3x3_pkg::OUT_COL_W-1:0]       o_out_col,
    output logic                                  o_last
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = (CW + 1 > ic3x3_pkg::WIDTH_REG_W) ? CW + 1 : ic3x3_pkg::WIDTH_REG_W;
    localparam int HW  = ic3x3_pkg::HEIGHT_REG_W;
    localparam int RW  = ic3x3_pkg::ROW_W;
    localparam int SW  = PIXEL_BITS + COEF_BITS + 3;

    localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);
    localparam logic [HW-1:0]  MAXH = HW'(ic3x3_pkg::MAX_HEIGHT);

    // what travels beside the arithmetic from stage two to stage five
    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] px;
        logic [RW-1:0]                row;
        logic [CW-1:0]                col;
        logic                         need_a;   // filtered result for row-1, col-1
        logic                         need_b;   // pass-through border result
    } t_side;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ic3x3_pkg::WIDTH_REG_W-1:0]                      r_img_width;
    logic [HW-1:0]                                          r_img_height;
    logic [ic3x3_pkg::KSIZE-1:0][ic3x3_pkg::KERN_REG_W-1:0] r_kern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= ic3x3_pkg::RST_WIDTH;
            r_img_height <= ic3x3_pkg::RST_HEIGHT;
            r_kern       <= {ic3x3_pkg::KSIZE{ic3x3_pkg::RST_KERNEL}};
        end else if (i_cfg_valid) begin
            case (ic3x3_pkg::t_cfg_reg'(i_cfg_index))
                ic3x3_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_width <= i_cfg_data[ic3x3_pkg::WIDTH_REG_W-1:0];
                end
                ic3x3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_height <= i_cfg_data[HW-1:0];
                end
                ic3x3_pkg::CFG_KERNEL_TOP: begin
                    r_kern[0] <= i_cfg_data[ic3x3_pkg::KERN_REG_W-1:0];
                end
                ic3x3_pkg::CFG_KERNEL_MIDDLE: begin
                    r_kern[1] <= i_cfg_data[ic3x3_pkg::KERN_REG_W-1:0];
                end
                ic3x3_pkg::CFG_KERNEL_BOTTOM: begin
                    r_kern[2] <= i_cfg_data[ic3x3_pkg::KERN_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // effective frame size: zero acts as one, oversize clamps to the maximum
    logic [WCW-1:0] w_eff;
    logic [HW-1:0]  h_eff;

    always_comb begin
        if (r_img_width == '0) begin
            w_eff = WCW'(1);
        end else if (WCW'(r_img_width) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = WCW'(r_img_width);
        end
        if (r_img_height == '0) begin
            h_eff = HW'(1);
        end else if (r_img_height > MAXH) begin
            h_eff = MAXH;
        end else begin
            h_eff = r_img_height;
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic        adv;           // every stage moves one place
    logic        in_acc;
    logic [4:0]  r_valid;       // bit 0 is stage one, bit 4 is stage five
    logic        s1_go;

    assign o_in_ready = adv;
    assign in_acc     = i_in_valid && adv;
    assign s1_go      = adv && r_valid[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[3:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------
    logic [RW-1:0]  r_row_cnt;
    logic [CW-1:0]  r_col_cnt;
    logic [RW-1:0]  cur_row;
    logic [CW-1:0]  cur_col;
    logic [RW-1:0]  n_row_cnt;
    logic [CW-1:0]  n_col_cnt;
    logic [WCW-1:0] col_inc;
    logic [HW-1:0]  row_inc;

    always_comb begin
        cur_col = i_frame_start ? '0 : r_col_cnt;
        cur_row = i_frame_start ? '0 : r_row_cnt;
        col_inc = WCW'(cur_col) + WCW'(1);
        row_inc = HW'(cur_row) + HW'(1);
        if (col_inc >= w_eff) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col_cnt = col_inc[CW-1:0];
            n_row_cnt = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (in_acc) begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    // ------------------------------------------------------------------
    // stage one: input register and line store
    // ------------------------------------------------------------------
    logic signed [PIXEL_BITS-1:0] r_s1_px;
    logic [RW-1:0]                r_s1_row;
    logic [CW-1:0]                r_s1_col;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px  <= i_pixel;
            r_s1_row <= cur_row;
            r_s1_col <= cur_col;
        end
    end

    // one word per column: upper half two rows up, lower half one row up
    logic [2*PIXEL_BITS-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] r_mem_rd;
    logic [2*PIXEL_BITS-1:0] r_fwd_word;
    logic                    r_fwd;
    logic [2*PIXEL_BITS-1:0] s1_rd;
    logic [2*PIXEL_BITS-1:0] s1_word;
    logic [PIXEL_BITS-1:0]   s1_up;
    logic [PIXEL_BITS-1:0]   s1_upup;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_rd <= r_line_mem[cur_col];
        end
        if (s1_go) begin
            r_line_mem[r_s1_col] <= s1_word;
        end
    end

    // a one-pixel-wide frame reads the column that is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= s1_go && (cur_col == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_word <= s1_word;
        end
    end

    assign s1_rd   = r_fwd ? r_fwd_word : r_mem_rd;
    assign s1_up   = s1_rd[PIXEL_BITS-1:0];
    assign s1_upup = s1_rd[2*PIXEL_BITS-1:PIXEL_BITS];
    assign s1_word = {s1_up, r_s1_px};

    // ------------------------------------------------------------------
    // window: two previous columns of three pixels, top row first
    // ------------------------------------------------------------------
    logic [5:0][PIXEL_BITS-1:0]                      r_win;
    logic [ic3x3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]  mac_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_go) begin
            r_win <= {r_s1_px, s1_up, s1_upup, r_win[5], r_win[4], r_win[3]};
        end
    end

    // oldest column first, current column (upup, up, pixel) last
    assign mac_win = {r_s1_px, s1_up, s1_upup,
                      r_win[5], r_win[4], r_win[3], r_win[2], r_win[1], r_win[0]};

    // border and interior decisions for the stage one pixel
    logic [HW-1:0]  s1_row_x;
    logic [WCW-1:0] s1_col_x;
    logic           s1_need_a;
    logic           s1_need_b;

    always_comb begin
        s1_row_x  = HW'(r_s1_row);
        s1_col_x  = WCW'(r_s1_col);
        s1_need_a = (r_s1_row >= RW'(2)) && (r_s1_col >= CW'(2)) &&
                    (s1_row_x < h_eff) && (s1_col_x < w_eff);
        s1_need_b = (r_s1_row == '0) || (r_s1_col == '0) ||
                    (s1_row_x >= h_eff - HW'(1)) || (s1_col_x >= w_eff - WCW'(1));
    end

    // ------------------------------------------------------------------
    // stages two to five: products, sum, reciprocal, correction
    // ------------------------------------------------------------------
    logic signed [SW-1:0]         mac_sum;
    logic signed [PIXEL_BITS-1:0] div_value;

    ic3x3_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_win  (mac_win),
        .i_kern (r_kern),
        .o_sum  (mac_sum)
    );

    ic3x3_div9 #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_div9 (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_sum   (mac_sum),
        .o_value (div_value)
    );

    t_side r_s2;
    t_side r_s3;
    t_side r_s4;
    t_side r_s5;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2 <= '{px: r_s1_px, row: r_s1_row, col: r_s1_col,
                      need_a: s1_need_a, need_b: s1_need_b};
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s5 <= r_s4;
        end
    end

    // ------------------------------------------------------------------
    // result register: filtered result first, then the border result
    // ------------------------------------------------------------------
    logic                         r_sent_a;
    logic                         emit_a;
    logic                         emit_b;
    logic                         out_free;
    logic                         load_o;
    logic                         s5_done;
    logic                         r_o_valid;
    logic signed [PIXEL_BITS-1:0] r_o_value;
    logic [RW-1:0]                r_o_row;
    logic [ic3x3_pkg::OUT_COL_W-1:0] r_o_col;
    logic                         r_o_last;
    logic [CW-1:0]                s5_col_m1;

    always_comb begin
        emit_a   = r_valid[4] && r_s5.need_a && !r_sent_a;
        emit_b   = r_valid[4] && r_s5.need_b && !emit_a;
        out_free = !r_o_valid || i_out_ready;
        load_o   = (emit_a || emit_b) && out_free;
        // a pixel with no result leaves at once
        s5_done  = r_valid[4] &&
                   (!(emit_a || emit_b) || (out_free && (emit_b || !r_s5.need_b)));
        adv      = !r_valid[4] || s5_done;
        s5_col_m1 = r_s5.col - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_a  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_sent_a <= 1'b0;
            end else if (load_o && emit_a) begin
                r_sent_a <= 1'b1;
            end
            if (load_o) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_o) begin
            if (emit_a) begin
                r_o_value <= div_value;
                r_o_row   <= r_s5.row - RW'(1);
                r_o_col   <= ic3x3_pkg::OUT_COL_W'(s5_col_m1);
                r_o_last  <= !r_s5.need_b;
            end else begin
                r_o_value <= r_s5.px;
                r_o_row   <= r_s5.row;
                r_o_col   <= ic3x3_pkg::OUT_COL_W'(r_s5.col);
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_value     = r_o_value;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_last      = r_o_last;

endmodule

// ===== src/ic3x3_mac.sv =====
// ----------------------------------------------------------------------------
// ic3x3_mac: 3x3 multiply-accumulate
// Nine signed products in one register stage, their sum in the next.
// ----------------------------------------------------------------------------
module ic3x3_mac #(
    parameter int PIXEL_BITS = 16,
    parameter int COEF_BITS  = 8
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_en,
    input  logic [ic3x3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]         i_win,
    input  logic [ic3x3_pkg::KSIZE-1:0][ic3x3_pkg::KERN_REG_W-1:0] i_kern,
    output logic signed [PIXEL_BITS+COEF_BITS+2:0]                 o_sum
);

    localparam int PW  = PIXEL_BITS + COEF_BITS;
    localparam int SW  = PW + 3;
    localparam int KXW = (ic3x3_pkg::KSIZE * COEF_BITS > ic3x3_pkg::KERN_REG_W) ?
                         ic3x3_pkg::KSIZE * COEF_BITS : ic3x3_pkg::KERN_REG_W;

    logic [KXW-1:0]          kx     [ic3x3_pkg::KSIZE];
    logic signed [PW-1:0]    n_prod [ic3x3_pkg::WIN_TAPS];
    logic signed [PW-1:0]    r_prod [ic3x3_pkg::WIN_TAPS];
    logic signed [SW-1:0]    n_sum;
    logic signed [SW-1:0]    r_sum;

    // kernel rows, zero padded when the coefficients overrun the register
    always_comb begin
        for (int m = 0; m < ic3x3_pkg::KSIZE; m++) begin
            kx[m] = KXW'(i_kern[m]);
        end
    end

    // tap n*3+m is window column n (oldest first), kernel row m
    always_comb begin
        for (int n = 0; n < ic3x3_pkg::KSIZE; n++) begin
            for (int m = 0; m < ic3x3_pkg::KSIZE; m++) begin
                n_prod[n*ic3x3_pkg::KSIZE+m] =
                    $signed(i_win[n*ic3x3_pkg::KSIZE+m]) *
                    $signed(kx[m][COEF_BITS*n +: COEF_BITS]);
            end
        end
    end

    // balanced adder tree
    assign n_sum = ((SW'(r_prod[0]) + SW'(r_prod[1])) + (SW'(r_prod[2]) + SW'(r_prod[3])))
                 + ((SW'(r_prod[4]) + SW'(r_prod[5])) + (SW'(r_prod[6]) + SW'(r_prod[7])))
                 + SW'(r_prod[8]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== src/ic3x3_div9.sv =====
// ----------------------------------------------------------------------------
// ic3x3_div9: divide by nine toward zero and saturate
// Reciprocal multiply in the first stage, one-step correction and clamp in the second.
// ----------------------------------------------------------------------------
module ic3x3_div9 #(
    parameter int PIXEL_BITS = 16,
    parameter int COEF_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [PIXEL_BITS+COEF_BITS+2:0] i_sum,
    output logic signed [PIXEL_BITS-1:0]         o_value
);

    localparam int SW = PIXEL_BITS + COEF_BITS + 3;
    localparam int XW = PIXEL_BITS + 4;
    localparam int QW = XW - 3;

    // magnitudes above this saturate anyway
    localparam longint XMAX_L  = longint'(ic3x3_pkg::DIVISOR) * (longint'(1) << PIXEL_BITS) - 1;
    localparam longint RECIP_L = (longint'(1) << XW) / ic3x3_pkg::DIVISOR;
    localparam longint POS_L   = (longint'(1) << (PIXEL_BITS - 1)) - 1;

    localparam logic [SW-1:0] XMAX     = SW'(XMAX_L);
    localparam logic [QW-1:0] RECIP    = QW'(RECIP_L);
    localparam logic [QW-1:0] POS_MAX  = QW'(POS_L);
    localparam logic [QW-1:0] NEG_MAG  = QW'(POS_L + 1);

    logic [SW-1:0]          mag;
    logic [XW-1:0]          x;
    logic [XW+QW-1:0]       prod;
    logic [QW-1:0]          r_q0;
    logic [XW-1:0]          r_x;
    logic                   r_neg;
    logic [XW-1:0]          rem;
    logic [QW-1:0]          q;
    logic [QW-1:0]          nq;
    logic [PIXEL_BITS-1:0]  n_value;
    logic [PIXEL_BITS-1:0]  r_value;

    always_comb begin
        mag  = i_sum[SW-1] ? (~$unsigned(i_sum)) + SW'(1) : $unsigned(i_sum);
        x    = (mag > XMAX) ? XW'(XMAX) : mag[XW-1:0];
        prod = {QW'(0), x} * {XW'(0), RECIP};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0  <= prod[XW+QW-1:XW];
            r_x   <= x;
            r_neg <= i_sum[SW-1];
        end
    end

    // the reciprocal estimate is low by at most one
    always_comb begin
        rem = r_x - XW'(r_q0) * XW'(ic3x3_pkg::DIVISOR);
        q   = r_q0 + QW'(rem >= XW'(ic3x3_pkg::DIVISOR));
        nq  = ~q + QW'(1);
        if (!r_neg) begin
            n_value = (q > POS_MAX) ? {1'b0, {(PIXEL_BITS-1){1'b1}}} : q[PIXEL_BITS-1:0];
        end else begin
            n_value = (q > NEG_MAG) ? {1'b1, {(PIXEL_BITS-1){1'b0}}} : nq[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = $signed(r_value);

endmodule

// ===== sim/image_convolution_3x3_top_tb.sv =====
// ----------------------------------------------------------------------------
// image_convolution_3x3_top_tb: self-checking bench of the 3x3 convolution
// A clocked driver sends pixel beats taken from a queue that the stimulus
// fills. A clocked monitor mirrors the line store, window and counters to
// work out the results of every accepted pixel, then checks each returned
// result against them field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module image_convolution_3x3_top_tb;

    localparam int MAX_WIDTH     = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int COEF_BITS     = 8;
    localparam int RESET_CYCLES  = 5;
    // long enough for pixels that yield nothing to leave the pipeline
    localparam int DRAIN_CYCLES  = 16;
    // many times the longest sender gap plus the longest receiver stall
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_TARGET = 560;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic                         frame_start;
    } t_pixel_beat;

    typedef struct {
        logic signed [PIXEL_BITS-1:0]        value;
        logic [ic3x3_pkg::ROW_W-1:0]         row;
        logic [ic3x3_pkg::OUT_COL_W-1:0]     col;
        logic                                last;
    } t_result_beat;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block inputs, all known from time zero
    logic                                cfg_valid      = 1'b0;
    ic3x3_pkg::t_cfg_reg                 cfg_index      = ic3x3_pkg::CFG_IMAGE_WIDTH;
    logic [ic3x3_pkg::CFG_DATA_W-1:0]    cfg_data       = '0;
    logic                                in_valid       = 1'b0;
    logic signed [PIXEL_BITS-1:0]        in_pixel       = '0;
    logic                                in_frame_start = 1'b0;
    logic                                out_ready      = 1'b0;

    // block outputs
    logic                                o_cfg_ready;
    logic                                o_in_ready;
    logic                                o_out_valid;
    logic signed [PIXEL_BITS-1:0]        o_value;
    logic [ic3x3_pkg::ROW_W-1:0]         o_out_row;
    logic [ic3x3_pkg::OUT_COL_W-1:0]     o_out_col;
    logic                                o_last;

    image_convolution_3x3_top #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS),
        .COEF_BITS     (COEF_BITS)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (in_pixel),
        .i_frame_start (in_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_value       (o_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last        (o_last)
    );

    // pixels waiting to be sent and results waiting to come back
    t_pixel_beat  pending_pixels[$];
    t_result_beat predicted_results[$];

    // shadow of the register file, at reset values
    logic [ic3x3_pkg::WIDTH_REG_W-1:0]  width_reg   = ic3x3_pkg::RST_WIDTH;
    logic [ic3x3_pkg::HEIGHT_REG_W-1:0] height_reg  = ic3x3_pkg::RST_HEIGHT;
    logic [ic3x3_pkg::KERN_REG_W-1:0]   kernel_rows [ic3x3_pkg::KSIZE] =
        '{ic3x3_pkg::RST_KERNEL, ic3x3_pkg::RST_KERNEL, ic3x3_pkg::RST_KERNEL};

    // shadow of the line store, window and position counters
    logic signed [PIXEL_BITS-1:0] line_mem [2*MAX_WIDTH] = '{default: '0};
    logic signed [PIXEL_BITS-1:0] win_cols [6]           = '{default: '0};
    int unsigned                  row_pos = 0;
    int unsigned                  col_pos = 0;

    // run bookkeeping
    bit steady          = 1'b0;    // no gaps and no stalls while set
    int in_gap          = 0;
    int out_stall       = 0;
    int quiet_cycles    = 0;
    int fail_count      = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int filtered_count  = 0;
    int saturated_count = 0;
    int settings_count  = 0;

    // mostly short pauses, a few long ones
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // signed coefficient of kernel row m, column n
    function automatic longint coef(int m, int n);
        logic signed [COEF_BITS-1:0] c;
        c = kernel_rows[m][n*COEF_BITS +: COEF_BITS];
        return longint'(c);
    endfunction

    task automatic apply_reg(input ic3x3_pkg::t_cfg_reg idx,
                             input logic [ic3x3_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ic3x3_pkg::CFG_IMAGE_WIDTH:   width_reg  = data[ic3x3_pkg::WIDTH_REG_W-1:0];
            ic3x3_pkg::CFG_IMAGE_HEIGHT:  height_reg = data[ic3x3_pkg::HEIGHT_REG_W-1:0];
            ic3x3_pkg::CFG_KERNEL_TOP:    kernel_rows[0] = data;
            ic3x3_pkg::CFG_KERNEL_MIDDLE: kernel_rows[1] = data;
            ic3x3_pkg::CFG_KERNEL_BOTTOM: kernel_rows[2] = data;
            default: ;
        endcase
    endtask

    // one pixel into the shadow pipeline, its results onto the queue
    task automatic convolve_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic fs);
        int unsigned                  w;
        int unsigned                  h;
        int unsigned                  r;
        int unsigned                  c;
        int                           m;
        longint                       acc;
        longint                       q;
        logic signed [PIXEL_BITS-1:0] col3 [ic3x3_pkg::KSIZE];
        t_result_beat                 res;
        t_result_beat                 found[$];

        w = 32'(width_reg);
        h = 32'(height_reg);
        if (w < 1)                     w = 1;
        if (w > MAX_WIDTH)             w = MAX_WIDTH;
        if (h < 1)                     h = 1;
        if (h > ic3x3_pkg::MAX_HEIGHT) h = ic3x3_pkg::MAX_HEIGHT;

        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        // column of three: two rows up, one row up, this pixel
        col3[0] = '0;
        col3[1] = '0;
        col3[2] = px;
        if (c < MAX_WIDTH) begin
            col3[0] = line_mem[MAX_WIDTH + c];
            col3[1] = line_mem[c];
            line_mem[MAX_WIDTH + c] = col3[1];
            line_mem[c] = px;
        end

        // interior pixel up and left is complete now
        if (r >= 2 && c >= 2 && r - 1 < h - 1 && c - 1 < w - 1) begin
            acc = 0;
            for (m = 0; m < ic3x3_pkg::KSIZE; m++) begin
                acc += longint'(win_cols[m])     * coef(m, 0);
                acc += longint'(win_cols[3 + m]) * coef(m, 1);
                acc += longint'(col3[m])         * coef(m, 2);
            end
            q = acc / ic3x3_pkg::DIVISOR;    // truncates toward zero
            if (q > 32767 || q < -32768)
                saturated_count++;
            if (q > 32767)  q = 32767;
            if (q < -32768) q = -32768;
            res.value = q[PIXEL_BITS-1:0];
            res.row   = ic3x3_pkg::ROW_W'(r - 1);
            res.col   = ic3x3_pkg::OUT_COL_W'(c - 1);
            res.last  = 1'b0;
            found.push_back(res);
            filtered_count++;
        end

        // border pixel passes straight through
        if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1) begin
            res.value = px;
            res.row   = ic3x3_pkg::ROW_W'(r);
            res.col   = ic3x3_pkg::OUT_COL_W'(c);
            res.last  = 1'b0;
            found.push_back(res);
        end

        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            predicted_results.push_back(found[i]);

        for (m = 0; m < ic3x3_pkg::KSIZE; m++) begin
            win_cols[m]     = win_cols[3 + m];
            win_cols[3 + m] = col3[m];
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic compare_result(input t_result_beat want, input t_result_beat got);
        if (got.value !== want.value) begin
            fail_count++;
            $error("value at row %0d col %0d: expected %0d, got %0d",
                   want.row, want.col, want.value, got.value);
        end
        if (got.row !== want.row) begin
            fail_count++;
            $error("out_row: expected %0d, got %0d", want.row, got.row);
        end
        if (got.col !== want.col) begin
            fail_count++;
            $error("out_col: expected %0d, got %0d", want.col, got.col);
        end
        if (got.last !== want.last) begin
            fail_count++;
            $error("last at row %0d col %0d: expected %0d, got %0d",
                   want.row, want.col, want.last, got.last);
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel driver: holds a beat until accepted, then a random gap
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_pixels
        t_pixel_beat beat;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                beat = pending_pixels.pop_front();
                in_pixel       <= beat.pixel;
                in_frame_start <= beat.frame_start;
                in_valid       <= 1'b1;
                in_gap = pick_pause();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks results, predicts accepted pixels, tracks register
    // writes, runs the watchdog and drives the receiver's ready
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch_channels
        t_result_beat got;
        t_result_beat want;
        bit           out_beat;
        bit           any_beat;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_beat = o_out_valid && out_ready;
            any_beat = out_beat || (in_valid && o_in_ready) || (cfg_valid && o_cfg_ready);

            // results first, so a pixel never meets its own results in one edge
            if (out_beat) begin
                got = '{o_value, o_out_row, o_out_col, o_last};
                results_checked++;
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    $error("unexpected result: value %0d row %0d col %0d last %0d",
                           got.value, got.row, got.col, got.last);
                end else begin
                    want = predicted_results.pop_front();
                    compare_result(want, got);
                end
            end
            if (in_valid && o_in_ready) begin
                convolve_pixel(in_pixel, in_frame_start);
                pixels_sent++;
            end
            if (cfg_valid && o_cfg_ready)
                apply_reg(cfg_index, cfg_data);

            quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat on any channel for %0d cycles, %0d results owed",
                         quiet_cycles, predicted_results.size());
                $display("image_convolution_3x3_top regression: fail");
                $finish;
            end else if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                // stall after some beats
                if (out_beat)
                    out_stall = pick_pause();
                out_ready <= (out_stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input ic3x3_pkg::t_cfg_reg idx,
                             input logic [ic3x3_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic fs);
        t_pixel_beat beat;
        beat.pixel       = px;
        beat.frame_start = fs;
        pending_pixels.push_back(beat);
    endtask

    // all sent, all results back, then let the pipeline empty out
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int choose_width();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(1, 6);
        if (roll < 80) return $urandom_range(7, 40);
        if (roll < 87) return 0;
        if (roll < 93) return MAX_WIDTH;
        return $urandom_range(MAX_WIDTH + 1, 2047);
    endfunction

    function automatic int choose_height();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(1, 6);
        if (roll < 80) return $urandom_range(7, 24);
        if (roll < 87) return 0;
        if (roll < 93) return ic3x3_pkg::MAX_HEIGHT;
        return $urandom_range(ic3x3_pkg::MAX_HEIGHT + 1, 8191);
    endfunction

    function automatic logic [ic3x3_pkg::KERN_REG_W-1:0] choose_kernel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return ic3x3_pkg::KERN_REG_W'($urandom());
        if (roll < 75)    // small coefficients, from -2 to 2 each
            return {8'($urandom_range(0, 4) - 2), 8'($urandom_range(0, 4) - 2),
                    8'($urandom_range(0, 4) - 2)};
        case ($urandom_range(0, 3))
            0:       return 24'h808080;
            1:       return 24'h7f7f7f;
            2:       return 24'h000000;
            default: return ic3x3_pkg::RST_KERNEL;
        endcase
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] choose_pixel(int mode);
        if (mode == 0)
            return PIXEL_BITS'($urandom());
        if (mode == 1)
            return PIXEL_BITS'(int'($urandom_range(0, 600)) - 300);
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return PIXEL_BITS'($urandom());
        endcase
    endfunction

    function automatic int clamp(int v, int hi);
        if (v < 1)  return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    initial begin : stimulus
        int i;
        int n_items;
        int mode;
        int cur_w;
        int cur_h;
        int next_w;
        int random_items;
        bit wrote;
        bit need_fs;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // a couple of row-0 pixels under reset settings
        push_pixel(16'sh7fff, 1'b1);
        push_pixel(16'sh8000, 1'b0);
        wait_idle();

        // 3x3 frames, one interior pixel each: positive then negative
        // saturation, then a small negative sum that must round toward zero
        write_reg(ic3x3_pkg::CFG_IMAGE_WIDTH, ic3x3_pkg::CFG_DATA_W'(3));
        write_reg(ic3x3_pkg::CFG_IMAGE_HEIGHT, ic3x3_pkg::CFG_DATA_W'(3));
        write_reg(ic3x3_pkg::CFG_KERNEL_TOP, 24'h808080);
        write_reg(ic3x3_pkg::CFG_KERNEL_MIDDLE, 24'h808080);
        write_reg(ic3x3_pkg::CFG_KERNEL_BOTTOM, 24'h808080);
        settings_count++;
        for (i = 0; i < 9; i++)
            push_pixel(16'sh8000, i == 0);
        wait_idle();

        write_reg(ic3x3_pkg::CFG_KERNEL_TOP, 24'h7f7f7f);
        write_reg(ic3x3_pkg::CFG_KERNEL_MIDDLE, 24'h7f7f7f);
        write_reg(ic3x3_pkg::CFG_KERNEL_BOTTOM, 24'h7f7f7f);
        settings_count++;
        for (i = 0; i < 9; i++)
            push_pixel(16'sh8000, i == 0);
        wait_idle();

        write_reg(ic3x3_pkg::CFG_KERNEL_TOP, ic3x3_pkg::RST_KERNEL);
        write_reg(ic3x3_pkg::CFG_KERNEL_MIDDLE, ic3x3_pkg::RST_KERNEL);
        write_reg(ic3x3_pkg::CFG_KERNEL_BOTTOM, ic3x3_pkg::RST_KERNEL);
        settings_count++;
        for (i = 0; i < 9; i++)
            push_pixel((i == 4) ? 16'shfffe : 16'shffff, i == 0);
        wait_idle();

        // widest row and tallest frame: one full row plus a few pixels
        write_reg(ic3x3_pkg::CFG_IMAGE_WIDTH, ic3x3_pkg::CFG_DATA_W'(MAX_WIDTH));
        write_reg(ic3x3_pkg::CFG_IMAGE_HEIGHT, ic3x3_pkg::CFG_DATA_W'(ic3x3_pkg::MAX_HEIGHT));
        write_reg(ic3x3_pkg::CFG_KERNEL_MIDDLE, choose_kernel());
        settings_count++;
        for (i = 0; i < MAX_WIDTH + 6; i++)
            push_pixel(choose_pixel(0), i == 0);
        wait_idle();
        cur_w = MAX_WIDTH;
        cur_h = ic3x3_pkg::MAX_HEIGHT;

        // random settings, mostly whole small frames with random content
        random_items = 0;
        while (random_items < RANDOM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            wrote  = 1'b0;
            next_w = cur_w;
            if ($urandom_range(0, 1)) begin
                i = choose_width();
                write_reg(ic3x3_pkg::CFG_IMAGE_WIDTH, ic3x3_pkg::CFG_DATA_W'(i));
                next_w = clamp(i, MAX_WIDTH);
                wrote  = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
                i = choose_height();
                write_reg(ic3x3_pkg::CFG_IMAGE_HEIGHT, ic3x3_pkg::CFG_DATA_W'(i));
                cur_h = clamp(i, ic3x3_pkg::MAX_HEIGHT);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 4) < 2) begin
                write_reg(ic3x3_pkg::CFG_KERNEL_TOP, choose_kernel());
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 4) < 2)
                write_reg(ic3x3_pkg::CFG_KERNEL_MIDDLE, choose_kernel());
            if ($urandom_range(0, 4) < 2)
                write_reg(ic3x3_pkg::CFG_KERNEL_BOTTOM, choose_kernel());
            settings_count++;

            // a wider row would read line store entries not yet written in
            // this frame, so it always restarts the frame; otherwise the
            // stream may carry on from where it stood
            need_fs = (next_w > cur_w) || $urandom_range(0, 1);
            cur_w   = next_w;

            n_items = $urandom_range(1, 3) * cur_w * cur_h + $urandom_range(0, cur_w);
            if (n_items > 150)
                n_items = $urandom_range(60, 150);
            mode = $urandom_range(0, 2);
            for (i = 0; i < n_items; i++)
                push_pixel(choose_pixel(mode),
                           (i == 0 && need_fs) || $urandom_range(0, 99) < 2);
            random_items += n_items;
            wait_idle();
        end

        if (predicted_results.size() != 0) begin
            fail_count++;
            $error("%0d results never arrived", predicted_results.size());
        end

        $display("covered %0d pixels and %0d results under %0d register settings",
                 pixels_sent, results_checked, settings_count);
        $display("%0d filtered results, %0d of them clipped to the pixel range",
                 filtered_count, saturated_count);
        if (fail_count == 0)
            $display("image_convolution_3x3_top regression: pass");
        else
            $display("image_convolution_3x3_top regression: fail");
        $finish;
    end

endmodule
